FILE: src/bsmr_pkg.sv
// Package for the sorted-array match-range search block.
// Holds the item types, field widths, operation codes and controller-datapath signals.
// Depends on nothing; every other file but bsmr_ram imports it.
package bsmr_pkg;

    localparam int unsigned DEPTH_DEFAULT = 1024;
    localparam int unsigned KEY_W         = 32;
    localparam int unsigned IDX_W         = 10;
    localparam int unsigned CNT_W         = 11;
    localparam int unsigned LEN_W         = 11;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic [IDX_W-1:0]        element_index;
        logic signed [KEY_W-1:0] key_or_value;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] final_index;
        logic [CNT_W-1:0] match_count;
    } res_t;

    typedef struct packed {
        logic load;
        logic init;
        logic cmp_en;
        logic rd_en;
        logic restart;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic active;
    } dp_status_t;

endpackage

FILE: src/binary_search_match_range.sv
// Top level of the sorted-array match-range search. Uses bsmr_pkg, bsmr_ctrl and bsmr_dp.
// A load item is written in its accept cycle and gives no result; busy stays low.
// A search over n elements reads the store once per cycle in each bound pass; done is
// registered from the controller's finish command, which follows the upper-bound pass.
// The next item may be accepted in the done cycle; the receiver cannot stall the result.
// Reset clears the controller and array_length; the element store is undefined until written.
module binary_search_match_range
    import bsmr_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             request,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_data,
    output logic             done,
    output res_t             result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bsmr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (request.operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    bsmr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .done     (done),
        .result   (result)
    );

endmodule

FILE: src/bsmr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module bsmr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/bsmr_ctrl.sv
// Controller state machine for the match-range search.
// Issues loads and sequences the lower-bound pass, the upper-bound pass and the result; uses bsmr_pkg.
module bsmr_ctrl
    import bsmr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       operation,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_STEP  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       pass_reg;
    logic       pass_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        pass_next  = pass_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_SEARCH)
                    begin
                        cmd.init   = 1'b1;
                        pass_next  = 1'b0;
                        state_next = S_PROBE;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_PROBE, S_STEP:
            begin
                cmd.cmp_en = (state_reg == S_STEP);
                if (status.active)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_STEP;
                end
                else if (!pass_reg)
                begin
                    cmd.restart = 1'b1;
                    pass_next   = 1'b1;
                    state_next  = S_PROBE;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: src/bsmr_dp.sv
// Datapath of the match-range search: element store, bound registers, comparator and result.
// Uses bsmr_pkg and bsmr_ram; driven by bsmr_ctrl.
module bsmr_dp
    import bsmr_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  req_t             request,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_data,
    input  ctrl_cmd_t        cmd,
    output dp_status_t       status,
    output logic             done,
    output res_t             result
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned NW = (CW > LEN_W) ? CW : LEN_W;

    logic [LEN_W-1:0]        len_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [NW-1:0]           n_reg;
    logic [NW-1:0]           lo_reg;
    logic [NW-1:0]           hi_reg;
    logic [NW-1:0]           mid_reg;
    logic [NW-1:0]           lower_reg;
    logic                    strict_reg;
    logic                    done_reg;
    res_t                    result_reg;

    logic signed [KEY_W-1:0] elem;
    logic                    go_right;
    logic [NW-1:0]           len_ext;
    logic [NW-1:0]           n_sat;
    logic [NW-1:0]           lo_eff;
    logic [NW-1:0]           hi_eff;
    logic [NW:0]             mid_sum;
    logic [NW-1:0]           mid_next;
    logic                    idx_ok;
    logic                    ram_we;
    logic [NW:0]             diff;
    logic [NW-1:0]           upper_m1;
    res_t                    result_next;

    assign idx_ok = (32'(request.element_index) < 32'(DEPTH));
    assign ram_we = cmd.load && idx_ok;

    bsmr_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(request.element_index)),
        .wdata (request.key_or_value),
        .re    (cmd.rd_en),
        .raddr (AW'(mid_next)),
        .rdata (elem)
    );

    assign len_ext = NW'(len_reg);
    assign n_sat   = (len_ext > NW'(DEPTH)) ? NW'(DEPTH) : len_ext;

    assign go_right = strict_reg ? (elem <= key_reg) : (elem < key_reg);
    assign lo_eff   = (cmd.cmp_en && go_right) ? (mid_reg + NW'(1)) : lo_reg;
    assign hi_eff   = (cmd.cmp_en && !go_right) ? mid_reg : hi_reg;
    assign mid_sum  = {1'b0, lo_eff} + {1'b0, hi_eff};
    assign mid_next = mid_sum[NW:1];
    assign status.active = (lo_eff < hi_eff);

    assign diff     = {1'b0, lo_eff} - {1'b0, lower_reg};
    assign upper_m1 = lo_eff - NW'(1);

    always_comb
    begin
        result_next = '0;
        if (lo_eff > lower_reg)
        begin
            result_next.found       = 1'b1;
            result_next.first_index = lower_reg[IDX_W-1:0];
            result_next.final_index = upper_m1[IDX_W-1:0];
            result_next.match_count = diff[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_data;
            end
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            key_reg    <= request.key_or_value;
            n_reg      <= n_sat;
            lo_reg     <= '0;
            hi_reg     <= n_sat;
            strict_reg <= 1'b0;
        end
        else if (cmd.restart)
        begin
            lower_reg  <= lo_eff;
            lo_reg     <= '0;
            hi_reg     <= n_reg;
            strict_reg <= 1'b1;
        end
        else if (cmd.cmp_en)
        begin
            lo_reg <= lo_eff;
            hi_reg <= hi_eff;
        end
        if (cmd.rd_en)
        begin
            mid_reg <= mid_next;
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for binary_search_match_range: loads sorted arrays, sets the
// in-use length and checks each search result against a predictor kept in a scoreboard.
// Depends on bsmr_pkg and the binary_search_match_range RTL.
module tb_top;
    import bsmr_pkg::*;

    localparam int unsigned SLOTS       = 1024;
    localparam int unsigned SETTLE      = 30;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned ITEM_TARGET = 200;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    class range_scoreboard;
        logic signed [KEY_W-1:0] elements [SLOTS];
        logic [LEN_W-1:0]        array_length;
        res_t                    expected_results [$];
        int                      errors;

        function new();
            array_length = '0;
            errors = 0;
            foreach (elements[i])
            begin
                elements[i] = '0;
            end
        endfunction

        function int unsigned bound_pos(int unsigned n, logic signed [KEY_W-1:0] key, bit strict);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            bit          go_right;
            lo = 0;
            hi = n;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                go_right = strict ? (elements[mid] <= key) : (elements[mid] < key);
                if (go_right)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return lo;
        endfunction

        function res_t equal_range(logic signed [KEY_W-1:0] key);
            int unsigned n;
            int unsigned lower;
            int unsigned upper;
            res_t        r;
            n = (array_length > SLOTS) ? SLOTS : array_length;
            lower = bound_pos(n, key, 1'b0);
            upper = bound_pos(n, key, 1'b1);
            r = '0;
            if (upper > lower)
            begin
                r.found       = 1'b1;
                r.first_index = IDX_W'(lower);
                r.final_index = IDX_W'(upper - 1);
                r.match_count = CNT_W'(upper - lower);
            end
            return r;
        endfunction

        function void note_item(req_t item);
            if (item.operation == OP_LOAD)
                elements[item.element_index] = item.key_or_value;
            else
                expected_results.push_back(equal_range(item.key_or_value));
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, actual found=%0d first=%0d final=%0d count=%0d",
                         $time, got.found, got.first_index, got.final_index, got.match_count);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch, expected found=%0d first=%0d final=%0d count=%0d",
                             $time, want.found, want.first_index, want.final_index,
                             want.match_count);
                    $display("%0t:           actual found=%0d first=%0d final=%0d count=%0d",
                             $time, got.found, got.first_index, got.final_index, got.match_count);
                    errors++;
                end
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    req_t             request = '0;
    logic             cfg_we = 1'b0;
    logic [LEN_W-1:0] cfg_data = '0;
    logic             done;
    res_t             result;

    range_scoreboard         board;
    logic signed [KEY_W-1:0] loaded_values [SLOTS];
    int unsigned             idle_pct = 0;
    int unsigned             quiet_cycles = 0;
    int unsigned             items_sent = 0;

    binary_search_match_range DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                board.array_length = cfg_data;
            if (start && !busy)
                board.note_item(request);
            if (done)
                board.check_result(result);
            if ((start && !busy) || done || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    task automatic send(input req_t item);
        int unsigned gap;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        else
        begin
            @(negedge clk);
        end
        start   <= 1'b1;
        request <= item;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    task automatic load(input int unsigned idx, input logic signed [KEY_W-1:0] value);
        req_t item;
        item.operation     = OP_LOAD;
        item.element_index = IDX_W'(idx);
        item.key_or_value  = value;
        loaded_values[idx] = value;
        send(item);
    endtask

    task automatic search(input logic signed [KEY_W-1:0] key);
        req_t item;
        item.operation     = OP_SEARCH;
        item.element_index = IDX_W'($urandom);
        item.key_or_value  = key;
        send(item);
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (board.expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] len);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= len;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Writes a non-decreasing run with frequent duplicates (all equal if all_equal is set) into positions 0 to len-1.
    task automatic fill(input int unsigned len, input bit all_equal);
        longint value;
        bit     top_at_max;
        case ($urandom_range(0, 3))
            0:       value = longint'(KEY_MIN);
            1:       value = longint'($urandom_range(0, 2000)) - 1000;
            default: value = longint'($signed($urandom));
        endcase
        top_at_max = ($urandom_range(0, 3) == 0);
        for (int unsigned i = 0; i < len; i++)
        begin
            if (top_at_max && i == len - 1)
                value = longint'(KEY_MAX);
            load(i, KEY_W'(value));
            if (!all_equal)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: value = value;
                    4, 5, 6, 7: value = value + $urandom_range(1, 3);
                    default:    value = value + $urandom_range(1, 1 << 20);
                endcase
                if (value > longint'(KEY_MAX))
                    value = longint'(KEY_MAX);
            end
        end
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key(input int unsigned n);
        logic signed [KEY_W-1:0] present;
        present = (n > 0) ? loaded_values[$urandom_range(0, n - 1)] : KEY_W'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return present;
            5:             return present + 1;
            6:             return present - 1;
            7:             return KEY_W'($urandom);
            8:             return KEY_MIN;
            default:       return KEY_MAX;
        endcase
    endfunction

    // Mostly searches; a few loads land outside the array in use and a few disturb its order.
    task automatic search_phase(input int unsigned count, input int unsigned in_use);
        int unsigned pick;
        for (int unsigned i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8 && in_use < SLOTS)
                load($urandom_range(in_use, SLOTS - 1), KEY_W'($urandom));
            else if (pick >= 8 && pick < 11 && in_use > 0)
                load($urandom_range(0, in_use - 1), KEY_W'($urandom));
            else
                search(pick_key(in_use));
        end
    endtask

    initial
    begin
        int unsigned len;
        board = new();
        foreach (loaded_values[i])
        begin
            loaded_values[i] = '0;
        end
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        search(0);
        search(KEY_MIN);
        load(0, KEY_MIN);
        load(1, 5);
        load(2, 5);
        load(3, KEY_MAX);
        set_length(4);
        search(KEY_MIN);
        search(5);
        search(KEY_MAX);
        search(4);
        search(6);
        search(-1);
        set_length(3);
        search(KEY_MAX);
        load(1, 100);
        search(5);
        search(100);

        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0:       len = 0;
                1:       len = $urandom_range(25, 200);
                2:       len = 1;
                default: len = $urandom_range(2, 24);
            endcase
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 25;
                default: idle_pct = 60;
            endcase
            set_length(LEN_W'(len));
            fill(len, $urandom_range(0, 7) == 0);
            search_phase($urandom_range(10, 40), len);
        end

        idle_pct = 0;
        set_length(LEN_W'(SLOTS));
        fill(SLOTS, 1'b0);
        search_phase(40, SLOTS);
        set_length('1);
        search_phase(20, SLOTS);
        set_length(LEN_W'($urandom_range(SLOTS + 1, (1 << LEN_W) - 2)));
        search_phase(20, SLOTS);

        settle();
        if (board.errors == 0 && board.expected_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule

FILE: binary_search_match_range.f
src/bsmr_pkg.sv
src/bsmr_ram.sv
src/bsmr_ctrl.sv
src/bsmr_dp.sv
src/binary_search_match_range.sv
test/tb_top.sv
